// ===== rtl/assert_macros.svh =====
// assertion macros used by the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("check failed");
// implication checked from the next edge on
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== rtl/fbb_pkg.sv =====
// package for the rectangle raster engine: screen size, modes, address width
// no dependencies
package fbb_pkg;
  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 240;
  localparam int NPIX = SCREEN_W * SCREEN_H;
  localparam int AW = $clog2(NPIX);
  localparam int KEY_SHIFT = 24;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_PUT   = 3'd1;
  localparam logic [2:0] MODE_GET   = 3'd2;
  localparam logic [2:0] MODE_FILL  = 3'd3;
  localparam logic [2:0] MODE_BLIT  = 3'd4;
  localparam logic [2:0] MODE_COPY  = 3'd5;

  // memory port bundle from the sequencer
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage

// ===== rtl/framebuffer_rect_blit_engine.sv =====
// top level of the rectangle raster engine: sequencer plus frame store
// depends on fbb_pkg, fbb_seq, fbb_store
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, mode x y width ...     | command in
//  out     | out_valid/out_ready, read_pixel on_screen | result out
//
// put and blit write in the accept cycle; get waits in a read state for the
// registered read data. fill writes one clipped pixel per cycle; copy moves
// one clipped pixel per cycle, a pace set by the single read and single write
// port of the frame store; clear writes every pixel of the frame store.
// after reset a clearing pass over every pixel runs before in_ready rises.
// a stalled result holds the block; one command is worked on at a time.
module framebuffer_rect_blit_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic signed [13:0] in_x,
  input  logic signed [13:0] in_y,
  input  logic signed [13:0] in_width,
  input  logic signed [13:0] in_height,
  input  logic signed [13:0] in_src_x,
  input  logic signed [13:0] in_src_y,
  input  logic [31:0]        in_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_read_pixel,
  output logic               out_on_screen
);
  fbb_pkg::mem_req_t req;
  logic [31:0] rdata;

  fbb_seq u_seq (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_x, .in_y, .in_width,
    .in_height, .in_src_x, .in_src_y, .in_color, .out_valid, .out_ready,
    .out_read_pixel, .out_on_screen, .req, .rdata
  );

  fbb_store u_store (.clk, .req, .rdata);
endmodule

// ===== rtl/fbb_store.sv =====
// frame store: one write port, one registered read port
// depends on fbb_pkg
module fbb_store (
  input  logic              clk,
  input  fbb_pkg::mem_req_t req,
  output logic [31:0]       rdata
);
  logic [31:0] mem [fbb_pkg::NPIX];

  // synchronous write and read
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end
endmodule

// ===== rtl/fbb_seq.sv =====
// command sequencer: clipping, pixel walk, read-modify-write of the store
// depends on fbb_pkg
module fbb_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_mode,
  input  logic signed [13:0]       in_x,
  input  logic signed [13:0]       in_y,
  input  logic signed [13:0]       in_width,
  input  logic signed [13:0]       in_height,
  input  logic signed [13:0]       in_src_x,
  input  logic signed [13:0]       in_src_y,
  input  logic [31:0]              in_color,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [31:0]              out_read_pixel,
  output logic                     out_on_screen,
  output fbb_pkg::mem_req_t        req,
  input  logic [31:0]              rdata
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_GET   = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_CLIP  = 3'd6;
  localparam int SW = fbb_pkg::SCREEN_W;
  localparam int SH = fbb_pkg::SCREEN_H;
  localparam int AW = fbb_pkg::AW;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] addr_r;
  logic [31:0] color_r;
  logic [2:0] mode_r;
  logic signed [17:0] x_r, y_r, w_r, h_r, sx_r, sy_r;
  logic [12:0] col_r, row_r;
  logic rev_r, rd_pend_r;
  logic [AW-1:0] wb_addr_r;
  logic [31:0] res_pix_r;
  logic res_hit_r;
  logic [AW-1:0] row_base_d, row_base_s;

  // signed extended inputs
  logic signed [17:0] ex, ey, ew, eh, esx, esy, dx, dy;
  assign ex = 18'(in_x); assign ey = 18'(in_y);
  assign ew = 18'(in_width); assign eh = 18'(in_height);
  assign esx = 18'(in_src_x); assign esy = 18'(in_src_y);
  assign dx = ex + esx; assign dy = ey + esy;

  logic put_on, blit_ok;
  assign put_on = (ex >= 0) && (ex < SW) && (ey >= 0) && (ey < SH);
  assign blit_ok = (ew > 0) && (eh > 0) && (esx >= 0) && (esx < ew) &&
                   (esy >= 0) && (esy < eh) && (dx >= 0) && (dx < SW) &&
                   (dy >= 0) && (dy < SH);

  // fill rectangle clipped to the screen
  logic signed [17:0] fx0, fy0, fw, fh;
  logic is_fill;
  assign is_fill = (in_mode == fbb_pkg::MODE_FILL);
  assign fx0 = (ex < 0) ? 18'sd0 : ex;
  assign fy0 = (ey < 0) ? 18'sd0 : ey;
  assign fw = (((ex + ew) > SW) ? 18'(SW) : (ex + ew)) - fx0;
  assign fh = (((ey + eh) > SH) ? 18'(SH) : (ey + eh)) - fy0;

  // on-screen flag at accept time; fill and copy set it later
  logic hit_in;
  always_comb begin
    case (in_mode)
      fbb_pkg::MODE_CLEAR: hit_in = 1'b1;
      fbb_pkg::MODE_PUT, fbb_pkg::MODE_GET: hit_in = put_on;
      fbb_pkg::MODE_BLIT: hit_in = blit_ok;
      default: hit_in = 1'b0;
    endcase
  end

  function automatic logic [AW-1:0] pix_addr(input logic signed [17:0] px,
                                              input logic signed [17:0] py);
    logic [31:0] a;
    a = 32'(py) * 32'(SW) + 32'(px);
    return a[AW-1:0];
  endfunction

  assign in_ready = (state_r == S_IDLE);

  // copy clipping stage values
  logic signed [17:0] cx, cy, cw, ch, csx, csy, t;
  always_comb begin
    cx = x_r; cy = y_r; cw = w_r; ch = h_r; csx = sx_r; csy = sy_r;
    if (csx < 0) begin cx = cx - csx; cw = cw + csx; csx = 18'sd0; end
    if (csy < 0) begin cy = cy - csy; ch = ch + csy; csy = 18'sd0; end
    if (cx < 0) begin csx = csx - cx; cw = cw + cx; cx = 18'sd0; end
    if (cy < 0) begin csy = csy - cy; ch = ch + cy; cy = 18'sd0; end
    t = 18'(SW) - csx; if (t < cw) cw = t;
    t = 18'(SW) - cx;  if (t < cw) cw = t;
    t = 18'(SH) - csy; if (t < ch) ch = t;
    t = 18'(SH) - cy;  if (t < ch) ch = t;
  end

  // current walk row index (reverse for downward overlap)
  logic [12:0] cur_row;
  assign cur_row = rev_r ? 13'(h_r - 18'sd1 - 18'(row_r)) : row_r;
  assign row_base_d = pix_addr(x_r, y_r + 18'(cur_row));
  assign row_base_s = pix_addr(sx_r, sy_r + 18'(cur_row));

  logic last_col, last_row;
  assign last_col = (18'(col_r) == w_r - 18'sd1);
  assign last_row = (18'(row_r) == h_r - 18'sd1);

  // column direction: right-to-left when rows coincide and dest is right
  logic rcol_r;
  logic [12:0] rev_col;
  assign rev_col = rcol_r ? 13'(w_r - 18'sd1 - 18'(col_r)) : col_r;

  // memory requests and next state; copy writes back the word read the cycle before
  always_comb begin
    req = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        req.we = 1'b1; req.waddr = addr_r; req.wdata = color_r;
        if (addr_r == AW'(fbb_pkg::NPIX - 1)) state_nxt = (mode_r == fbb_pkg::MODE_CLEAR
          && res_hit_r) ? S_OUT : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            fbb_pkg::MODE_CLEAR: state_nxt = S_CLEAR;
            fbb_pkg::MODE_PUT: begin
              req.we = put_on; req.waddr = pix_addr(ex, ey); req.wdata = in_color;
              state_nxt = S_OUT;
            end
            fbb_pkg::MODE_GET: begin
              req.re = put_on; req.raddr = pix_addr(ex, ey);
              state_nxt = put_on ? S_GET : S_OUT;
            end
            fbb_pkg::MODE_FILL: state_nxt = S_FILL;
            fbb_pkg::MODE_BLIT: begin
              req.we = blit_ok && (in_color[31:fbb_pkg::KEY_SHIFT] != '0);
              req.waddr = pix_addr(dx, dy); req.wdata = in_color;
              state_nxt = S_OUT;
            end
            fbb_pkg::MODE_COPY: state_nxt = S_CLIP;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_FILL: begin
        if (w_r <= 0 || h_r <= 0) state_nxt = S_OUT;
        else begin
          req.we = 1'b1; req.waddr = row_base_d + AW'(col_r); req.wdata = color_r;
          if (last_col && last_row) state_nxt = S_OUT;
        end
      end
      S_GET: state_nxt = S_OUT;
      S_CLIP: state_nxt = (cw > 0 && ch > 0) ? S_COPY : S_OUT;
      S_COPY: begin
        req.we = rd_pend_r; req.waddr = wb_addr_r; req.wdata = rdata;
        if (rd_pend_r && !(18'(row_r) < h_r)) state_nxt = S_OUT;
        else if (18'(row_r) < h_r) begin
          req.re = 1'b1;
          req.raddr = row_base_s + AW'(rev_col);
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; addr_r <= '0; color_r <= '0; mode_r <= 3'd7;
      res_hit_r <= 1'b0; rd_pend_r <= 1'b0; rev_r <= 1'b0; rcol_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: addr_r <= addr_r + AW'(1);
        S_IDLE: if (in_valid) begin
          mode_r <= in_mode; color_r <= in_color; addr_r <= '0;
          col_r <= '0; row_r <= '0; rd_pend_r <= 1'b0; res_pix_r <= '0;
          rev_r <= 1'b0; rcol_r <= 1'b0;
          x_r <= is_fill ? fx0 : ex;
          y_r <= is_fill ? fy0 : ey;
          w_r <= is_fill ? fw : ew;
          h_r <= is_fill ? fh : eh;
          sx_r <= esx; sy_r <= esy;
          res_hit_r <= hit_in;
        end
        S_FILL: begin
          if (w_r > 0 && h_r > 0) begin
            res_hit_r <= 1'b1;
            if (last_col) begin col_r <= '0; row_r <= row_r + 13'd1; end
            else col_r <= col_r + 13'd1;
          end
        end
        S_GET: res_pix_r <= rdata;
        S_CLIP: begin
          x_r <= cx; y_r <= cy; w_r <= cw; h_r <= ch; sx_r <= csx; sy_r <= csy;
          rev_r <= (cy > csy); rcol_r <= (cy == csy) && (cx > csx);
          res_hit_r <= (cw > 0 && ch > 0);
        end
        S_COPY: begin
          rd_pend_r <= (18'(row_r) < h_r);
          wb_addr_r <= row_base_d + AW'(rev_col);
          if (18'(row_r) < h_r) begin
            if (last_col) begin col_r <= '0; row_r <= row_r + 13'd1; end
            else col_r <= col_r + 13'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_read_pixel = res_pix_r;
  assign out_on_screen = res_hit_r;
endmodule

// ===== rtl/fbb_checker.sv =====
// port checker for the raster engine, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module fbb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_pixel,
  input logic        out_on_screen
);
  `CHK_ALWAYS(a_no_overlap, clk, rst_n, !(in_ready && out_valid))
  `CHK_ALWAYS(a_pix_hit, clk, rst_n, !out_valid || out_on_screen || out_read_pixel == 32'd0)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_pixel))
  `CHK_NEXT(a_in_done, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind framebuffer_rect_blit_engine fbb_checker u_chk (.*);
